FILE: src/mtp_pkg.sv
// Shared types and codes of the MIDI track event parser.
// No dependencies; used by every other file of the block but mtp_if.
package mtp_pkg;

	// result kinds
	localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
	localparam logic [2:0] KIND_CTRL     = 3'd2;
	localparam logic [2:0] KIND_PROGRAM  = 3'd3;
	localparam logic [2:0] KIND_BEND     = 3'd4;
	localparam logic [2:0] KIND_TEMPO    = 3'd5;
	localparam logic [2:0] KIND_ERROR    = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_BAD_DELTA   = 3'd1;
	localparam logic [2:0] ERR_END_DELTA   = 3'd2;
	localparam logic [2:0] ERR_NO_RUNNING  = 3'd3;
	localparam logic [2:0] ERR_CUT_META    = 3'd4;
	localparam logic [2:0] ERR_META_LEN    = 3'd5;
	localparam logic [2:0] ERR_BAD_SYSEX   = 3'd6;
	localparam logic [2:0] ERR_CUT_EVENT   = 3'd7;

	// status bytes and nibbles
	localparam logic [7:0] ST_META      = 8'hFF;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
	localparam logic [7:0] ST_SYSTEM    = 8'hF0;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
	localparam logic [3:0] HI_NOTE_ON   = 4'h9;
	localparam logic [3:0] HI_CTRL      = 4'hB;
	localparam logic [3:0] HI_PROGRAM   = 4'hC;
	localparam logic [3:0] HI_PRESSURE  = 4'hD;
	localparam logic [3:0] HI_BEND      = 4'hE;

	localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
	localparam logic [27:0] TEMPO_LEN     = 28'd3;

	// result queue between parser and output stage
	localparam int QUEUE_DEPTH = 4;

	// raw result as the parser leaves it in the queue
	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  chan;
		logic [6:0]  data_a;
		logic [6:0]  data_b;
		logic [31:0] tick;
		logic [23:0] tempo;
		logic [2:0]  err;
	} mtp_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mtp_q_stat_t;

endpackage

FILE: src/mtp_if.sv
// Handshake interfaces for the track byte input and the event output.
// Depends on nothing; used by the top level.
interface midi_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_byte;
	logic       first_in_track;
	logic       last_in_track;

	modport source(output valid, track_byte, first_in_track, last_in_track, input ready);
	modport sink(input valid, track_byte, first_in_track, last_in_track, output ready);
endinterface

interface midi_event_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_kind;
	logic [3:0]         channel;
	logic [6:0]         first_data;
	logic [6:0]         second_data;
	logic signed [13:0] bend_value;
	logic [31:0]        event_tick;
	logic [23:0]        tempo_us;
	logic [2:0]         error_code;

	modport source(output valid, event_kind, channel, first_data, second_data, bend_value,
		event_tick, tempo_us, error_code, input ready);
	modport sink(input valid, event_kind, channel, first_data, second_data, bend_value,
		event_tick, tempo_us, error_code, output ready);
endinterface

FILE: src/midi_track_event_parser.sv
// Top level of the MIDI track event parser: parser, result queue and output stage.
// Depends on mtp_pkg, mtp_if, mtp_parser, mtp_queue and mtp_format.
//
// Takes one track byte per cycle with no gaps of its own: the parser updates its
// small state with each byte it accepts, so the byte is classified at once and
// any result it causes goes into a four-entry queue at the same clock edge. The
// output stage pops the queue into an output register, so a result passes through
// a queue slot and then that register. Input ready drops only when the queue is
// full, which happens only while the event sink holds off. Write smpte_mode with
// cfg_we/cfg_wdata while no track is in flight; 1 drops tempo events. After an
// error result the parser ignores bytes until one with first_in_track set.
module midi_track_event_parser #(
	parameter int MAX_VARLEN_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	midi_byte_if.sink   track,
	midi_event_if.source events
);

	mtp_pkg::mtp_rec_t    rec;
	mtp_pkg::mtp_rec_t    rd_data;
	mtp_pkg::mtp_q_stat_t stat;
	logic                 emit;
	logic                 rd_en;
	logic                 accept;

	assign track.ready = !stat.full;
	assign accept      = track.valid && !stat.full;

	mtp_parser #(
		.MAX_VARLEN_BYTES(MAX_VARLEN_BYTES)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.track_byte    (track.track_byte),
		.first_in_track(track.first_in_track),
		.last_in_track (track.last_in_track),
		.emit          (emit),
		.rec           (rec)
	);

	mtp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (emit),
		.wr_data(rec),
		.rd_en  (rd_en),
		.rd_data(rd_data),
		.stat   (stat)
	);

	mtp_format u_format (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat       (stat),
		.rd_data    (rd_data),
		.rd_en      (rd_en),
		.out_ready  (events.ready),
		.out_valid  (events.valid),
		.event_kind (events.event_kind),
		.channel    (events.channel),
		.first_data (events.first_data),
		.second_data(events.second_data),
		.bend_value (events.bend_value),
		.event_tick (events.event_tick),
		.tempo_us   (events.tempo_us),
		.error_code (events.error_code)
	);

endmodule

FILE: src/mtp_parser.sv
// Front part: byte-level track parser that classifies each byte and raises raw results.
// Depends on mtp_pkg.
module mtp_parser #(
	parameter int MAX_VARLEN_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             accept,
	input  logic [7:0]       track_byte,
	input  logic             first_in_track,
	input  logic             last_in_track,
	output logic             emit,
	output mtp_pkg::mtp_rec_t rec
);

	localparam int CW = $clog2(MAX_VARLEN_BYTES + 1);

	typedef enum logic [9:0] {
		PH_DELTA      = 10'b0000000001,
		PH_STATUS     = 10'b0000000010,
		PH_DATA1      = 10'b0000000100,
		PH_DATA2      = 10'b0000001000,
		PH_META_TYPE  = 10'b0000010000,
		PH_META_LEN   = 10'b0000100000,
		PH_META_BODY  = 10'b0001000000,
		PH_TEMPO_BODY = 10'b0010000000,
		PH_SYSEX_LEN  = 10'b0100000000,
		PH_SYSEX_BODY = 10'b1000000000
	} mtp_phase_t;

	mtp_phase_t  phase_q, phase_d, e_phase;
	logic [31:0] tick_q, tick_d, e_tick;
	logic [27:0] acc_q, acc_d, e_acc, acc_f;
	logic [CW-1:0] cnt_q, cnt_d, e_cnt, cnt_f;
	logic [7:0]  rs_q, rs_d, e_rs;
	logic [7:0]  cur_q, cur_d;
	logic [6:0]  held_q, held_d;
	logic [7:0]  meta_q, meta_d;
	logic [27:0] bl_q, bl_d, bl_dec;
	logic [23:0] tempo_q, tempo_d;
	logic        halt_q, halt_d, e_halt;
	logic        smpte_q;
	logic        do_fail;
	logic [2:0]  fail_code;
	logic        done_f, over_f;

	function automatic logic one_data(input logic [7:0] st);
		one_data = (st[7:4] == mtp_pkg::HI_PROGRAM) || (st[7:4] == mtp_pkg::HI_PRESSURE);
	endfunction

	function automatic logic fin_emits(input logic [3:0] hi);
		case (hi) inside
			mtp_pkg::HI_NOTE_OFF, mtp_pkg::HI_NOTE_ON, mtp_pkg::HI_CTRL,
			mtp_pkg::HI_PROGRAM, mtp_pkg::HI_BEND: fin_emits = 1'b1;
			default: fin_emits = 1'b0;
		endcase
	endfunction

	function automatic logic [2:0] fin_kind(input logic [3:0] hi);
		case (hi)
			mtp_pkg::HI_NOTE_OFF: fin_kind = mtp_pkg::KIND_NOTE_OFF;
			mtp_pkg::HI_NOTE_ON:  fin_kind = mtp_pkg::KIND_NOTE_ON;
			mtp_pkg::HI_CTRL:     fin_kind = mtp_pkg::KIND_CTRL;
			mtp_pkg::HI_PROGRAM:  fin_kind = mtp_pkg::KIND_PROGRAM;
			default:              fin_kind = mtp_pkg::KIND_BEND;
		endcase
	endfunction

	always_comb begin
		// track start clears before the byte is parsed
		e_phase = first_in_track ? PH_DELTA : phase_q;
		e_tick  = first_in_track ? 32'd0 : tick_q;
		e_acc   = first_in_track ? 28'd0 : acc_q;
		e_cnt   = first_in_track ? CW'(0) : cnt_q;
		e_rs    = first_in_track ? 8'd0 : rs_q;
		e_halt  = first_in_track ? 1'b0 : halt_q;

		acc_f  = {e_acc[20:0], track_byte[6:0]};
		cnt_f  = e_cnt + CW'(1);
		done_f = !track_byte[7];
		over_f = track_byte[7] && (cnt_f >= CW'(MAX_VARLEN_BYTES));
		bl_dec = bl_q - 28'd1;

		phase_d = e_phase;
		tick_d  = e_tick;
		acc_d   = e_acc;
		cnt_d   = e_cnt;
		rs_d    = e_rs;
		cur_d   = cur_q;
		held_d  = held_q;
		meta_d  = meta_q;
		bl_d    = bl_q;
		tempo_d = tempo_q;
		halt_d  = e_halt;

		emit      = 1'b0;
		do_fail   = 1'b0;
		fail_code = mtp_pkg::ERR_NONE;
		rec       = '0;

		if (!e_halt) begin
			case (e_phase)
				PH_STATUS: begin
					if (!track_byte[7]) begin
						if (e_rs == 8'd0) begin
							do_fail   = 1'b1;
							fail_code = mtp_pkg::ERR_NO_RUNNING;
						end else begin
							cur_d  = e_rs;
							held_d = track_byte[6:0];
							if (one_data(e_rs)) begin
								phase_d     = PH_DELTA;
								acc_d       = '0;
								cnt_d       = '0;
								emit        = fin_emits(e_rs[7:4]);
								rec.kind    = fin_kind(e_rs[7:4]);
								rec.chan    = e_rs[3:0];
								rec.data_a  = track_byte[6:0];
							end else begin
								phase_d   = PH_DATA2;
								do_fail   = last_in_track;
								fail_code = mtp_pkg::ERR_CUT_EVENT;
							end
						end
					end else begin
						cur_d = track_byte;
						rs_d  = (track_byte < mtp_pkg::ST_SYSTEM) ? track_byte : 8'd0;
						if (track_byte == mtp_pkg::ST_META) begin
							phase_d   = PH_META_TYPE;
							do_fail   = last_in_track;
							fail_code = mtp_pkg::ERR_CUT_META;
						end else if (track_byte == mtp_pkg::ST_SYSEX ||
							track_byte == mtp_pkg::ST_SYSEX_ESC) begin
							phase_d   = PH_SYSEX_LEN;
							acc_d     = '0;
							cnt_d     = '0;
							do_fail   = last_in_track;
							fail_code = mtp_pkg::ERR_BAD_SYSEX;
						end else begin
							phase_d   = PH_DATA1;
							do_fail   = last_in_track;
							fail_code = mtp_pkg::ERR_CUT_EVENT;
						end
					end
				end
				PH_DATA1: begin
					held_d = track_byte[6:0];
					if (one_data(cur_q)) begin
						phase_d    = PH_DELTA;
						acc_d      = '0;
						cnt_d      = '0;
						emit       = fin_emits(cur_q[7:4]);
						rec.kind   = fin_kind(cur_q[7:4]);
						rec.chan   = cur_q[3:0];
						rec.data_a = track_byte[6:0];
					end else begin
						phase_d   = PH_DATA2;
						do_fail   = last_in_track;
						fail_code = mtp_pkg::ERR_CUT_EVENT;
					end
				end
				PH_DATA2: begin
					phase_d    = PH_DELTA;
					acc_d      = '0;
					cnt_d      = '0;
					emit       = fin_emits(cur_q[7:4]);
					rec.kind   = fin_kind(cur_q[7:4]);
					rec.chan   = cur_q[3:0];
					rec.data_a = held_q;
					rec.data_b = track_byte[6:0];
				end
				PH_META_TYPE: begin
					meta_d    = track_byte;
					phase_d   = PH_META_LEN;
					acc_d     = '0;
					cnt_d     = '0;
					do_fail   = last_in_track;
					fail_code = mtp_pkg::ERR_META_LEN;
				end
				PH_META_LEN, PH_SYSEX_LEN: begin
					acc_d     = acc_f;
					cnt_d     = cnt_f;
					fail_code = (e_phase == PH_META_LEN) ? mtp_pkg::ERR_META_LEN :
						mtp_pkg::ERR_BAD_SYSEX;
					if (over_f) begin
						do_fail = 1'b1;
					end else if (!done_f) begin
						do_fail = last_in_track;
					end else begin
						bl_d = acc_f;
						if (acc_f == 28'd0) begin
							phase_d = PH_DELTA;
							acc_d   = '0;
							cnt_d   = '0;
						end else begin
							do_fail = last_in_track;
							if (e_phase == PH_SYSEX_LEN) begin
								phase_d = PH_SYSEX_BODY;
							end else begin
								tempo_d = '0;
								phase_d = (meta_q == mtp_pkg::META_TEMPO &&
									acc_f == mtp_pkg::TEMPO_LEN) ? PH_TEMPO_BODY : PH_META_BODY;
							end
						end
					end
				end
				PH_META_BODY, PH_TEMPO_BODY, PH_SYSEX_BODY: begin
					if (e_phase == PH_TEMPO_BODY) begin
						tempo_d = {tempo_q[15:0], track_byte};
					end
					bl_d      = bl_dec;
					fail_code = (e_phase == PH_SYSEX_BODY) ? mtp_pkg::ERR_BAD_SYSEX :
						mtp_pkg::ERR_META_LEN;
					if (bl_dec == 28'd0) begin
						phase_d   = PH_DELTA;
						acc_d     = '0;
						cnt_d     = '0;
						emit      = (e_phase == PH_TEMPO_BODY) && !smpte_q;
						rec.kind  = mtp_pkg::KIND_TEMPO;
						rec.tempo = {tempo_q[15:0], track_byte};
					end else begin
						do_fail = last_in_track;
					end
				end
				default: begin
					phase_d   = PH_DELTA;
					acc_d     = acc_f;
					cnt_d     = cnt_f;
					fail_code = mtp_pkg::ERR_BAD_DELTA;
					if (over_f) begin
						do_fail = 1'b1;
					end else if (!done_f) begin
						do_fail = last_in_track;
					end else begin
						tick_d    = e_tick + {4'd0, acc_f};
						phase_d   = PH_STATUS;
						do_fail   = last_in_track;
						fail_code = mtp_pkg::ERR_END_DELTA;
					end
				end
			endcase
		end

		if (do_fail) begin
			halt_d   = 1'b1;
			emit     = 1'b1;
			rec      = '0;
			rec.kind = mtp_pkg::KIND_ERROR;
			rec.err  = fail_code;
		end
		rec.tick = tick_d;
		emit     = emit && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			tick_q  <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			rs_q    <= '0;
			cur_q   <= '0;
			held_q  <= '0;
			meta_q  <= '0;
			bl_q    <= '0;
			tempo_q <= '0;
			halt_q  <= 1'b0;
			smpte_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				smpte_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_d;
				tick_q  <= tick_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
				rs_q    <= rs_d;
				cur_q   <= cur_d;
				held_q  <= held_d;
				meta_q  <= meta_d;
				bl_q    <= bl_d;
				tempo_q <= tempo_d;
				halt_q  <= halt_d;
			end
		end
	end

endmodule

FILE: src/mtp_queue.sv
// Short result queue between the parser and the output stage.
// Depends on mtp_pkg.
module mtp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  mtp_pkg::mtp_rec_t wr_data,
	input  logic              rd_en,
	output mtp_pkg::mtp_rec_t rd_data,
	output mtp_pkg::mtp_q_stat_t stat
);

	localparam int DEPTH = mtp_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	mtp_pkg::mtp_rec_t slot_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [AW:0]       count_q;

	assign stat.full  = (count_q == (AW + 1)'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (AW + 1)'(1);
				2'b01:   count_q <= count_q - (AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW + 1)'(DEPTH))
		else $error("result queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !stat.empty)
		else $error("result queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !stat.full)
		else $error("result queue pushed while full");

endmodule

FILE: src/mtp_format.sv
// Back part: pops raw results, finishes their fields and holds them in the output register.
// Depends on mtp_pkg.
module mtp_format (
	input  logic                clk,
	input  logic                arst_n,
	input  mtp_pkg::mtp_q_stat_t stat,
	input  mtp_pkg::mtp_rec_t   rd_data,
	output logic                rd_en,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [2:0]          event_kind,
	output logic [3:0]          channel,
	output logic [6:0]          first_data,
	output logic [6:0]          second_data,
	output logic signed [13:0]  bend_value,
	output logic [31:0]         event_tick,
	output logic [23:0]         tempo_us,
	output logic [2:0]          error_code
);

	logic               valid_q;
	logic [2:0]         kind_f;
	logic [6:0]         a_f, b_f;
	logic signed [13:0] bend_f;
	logic [23:0]        tempo_f;

	assign rd_en     = !stat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_comb begin
		kind_f  = rd_data.kind;
		a_f     = rd_data.data_a;
		b_f     = rd_data.data_b;
		bend_f  = '0;
		tempo_f = rd_data.tempo;
		case (rd_data.kind)
			mtp_pkg::KIND_NOTE_ON: begin
				if (rd_data.data_b == 7'd0) begin
					kind_f = mtp_pkg::KIND_NOTE_OFF;
				end
			end
			mtp_pkg::KIND_BEND: begin
				// msb*128 + lsb - 8192 flips the top bit
				bend_f = {~rd_data.data_b[6], rd_data.data_b[5:0], rd_data.data_a};
				a_f    = '0;
				b_f    = '0;
			end
			mtp_pkg::KIND_TEMPO: begin
				if (rd_data.tempo == 24'd0) begin
					tempo_f = mtp_pkg::TEMPO_DEFAULT;
				end
			end
			default: begin
				kind_f = rd_data.kind;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			event_kind  <= kind_f;
			channel     <= rd_data.chan;
			first_data  <= a_f;
			second_data <= b_f;
			bend_value  <= bend_f;
			event_tick  <= rd_data.tick;
			tempo_us    <= tempo_f;
			error_code  <= rd_data.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rd_en) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: bench/mtp_event_scoreboard_pkg.sv
// Scoreboard for the MIDI track event parser bench: a byte-level predictor of
// the parser and the store of events it expects. Depends on mtp_pkg.
package mtp_event_scoreboard_pkg;
	import mtp_pkg::*;

	localparam int MAX_VARLEN = 4;

	typedef enum logic [3:0] {
		AT_DELTA, AT_STATUS, AT_DATA1, AT_DATA2, AT_META_TYPE, AT_META_LEN,
		AT_META_BODY, AT_TEMPO_BODY, AT_SYSEX_LEN, AT_SYSEX_BODY
	} parse_at_t;

	typedef enum {VL_MORE, VL_DONE, VL_LONG} varlen_step_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  chan;
		logic [6:0]  data_a;
		logic [6:0]  data_b;
		logic [13:0] bend;
		logic [31:0] tick;
		logic [23:0] tempo;
		logic [2:0]  err;
	} track_event_t;

	class track_event_scoreboard;
		track_event_t pending[$];
		int unsigned  fail_count;

		local bit          smpte_mode;
		local parse_at_t   at;
		local logic [31:0] tick_sum;
		local logic [27:0] vl_acc;
		local logic [2:0]  vl_count;
		local logic [7:0]  running;
		local logic [7:0]  status;
		local logic [6:0]  held;
		local logic [7:0]  meta_kind;
		local logic [27:0] bytes_left;
		local logic [23:0] tempo_acc;
		local bit          halted;

		function new();
			fail_count = 0;
			smpte_mode = 1'b0;
			tick_sum = '0;
			running = '0;
			status = '0;
			held = '0;
			meta_kind = '0;
			bytes_left = '0;
			tempo_acc = '0;
			halted = 1'b0;
			to_delta();
		endfunction

		function void write_mode(bit m);
			smpte_mode = m;
		endfunction

		function bit idle();
			return pending.size() == 0;
		endfunction

		local function void to_delta();
			at = AT_DELTA;
			vl_acc = '0;
			vl_count = '0;
		endfunction

		local function void emit(logic [2:0] kind, logic [3:0] chan, logic [6:0] a,
				logic [6:0] b, logic [13:0] bend, logic [23:0] tempo, logic [2:0] err);
			track_event_t ev;
			ev.kind = kind;
			ev.chan = chan;
			ev.data_a = a;
			ev.data_b = b;
			ev.bend = bend;
			ev.tick = tick_sum;
			ev.tempo = tempo;
			ev.err = err;
			pending.insert(pending.size(), ev);
		endfunction

		local function void fail_with(logic [2:0] code);
			halted = 1'b1;
			emit(KIND_ERROR, 4'd0, 7'd0, 7'd0, 14'd0, 24'd0, code);
		endfunction

		local function varlen_step_t feed_varlen(logic [7:0] b);
			vl_acc = {vl_acc[20:0], b[6:0]};
			vl_count++;
			if (!b[7])
				return VL_DONE;
			if (vl_count >= MAX_VARLEN)
				return VL_LONG;
			return VL_MORE;
		endfunction

		local function bit one_data(logic [7:0] st);
			return st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE;
		endfunction

		local function void finish_event(logic [6:0] b2);
			logic [3:0] ch;
			ch = status[3:0];
			to_delta();
			case (status[7:4])
			HI_NOTE_OFF: emit(KIND_NOTE_OFF, ch, held, b2, 14'd0, 24'd0, ERR_NONE);
			HI_NOTE_ON: emit(b2 == 7'd0 ? KIND_NOTE_OFF : KIND_NOTE_ON, ch, held, b2,
				14'd0, 24'd0, ERR_NONE);
			HI_CTRL: emit(KIND_CTRL, ch, held, b2, 14'd0, 24'd0, ERR_NONE);
			HI_PROGRAM: emit(KIND_PROGRAM, ch, held, 7'd0, 14'd0, 24'd0, ERR_NONE);
			HI_BEND: emit(KIND_BEND, ch, 7'd0, 7'd0, {b2, held} - 14'd8192, 24'd0, ERR_NONE);
			default: ;
			endcase
		endfunction

		// Advance the parser by one accepted byte and queue any event it causes.
		function void note_byte(logic [7:0] b, bit first, bit last);
			logic [2:0]   cut;	// error raised if the track ends on this byte
			varlen_step_t vl;
			bit           was_tempo;
			cut = ERR_NONE;
			if (first) begin
				tick_sum = '0;
				running = '0;
				halted = 1'b0;
				to_delta();
			end
			if (halted)
				return;
			case (at)
			AT_STATUS: begin
				if (!b[7]) begin
					if (running == 8'd0) begin
						fail_with(ERR_NO_RUNNING);
						return;
					end
					status = running;
					held = b[6:0];
					if (one_data(status)) begin
						finish_event(7'd0);
						return;
					end
					at = AT_DATA2;
					cut = ERR_CUT_EVENT;
				end else begin
					status = b;
					running = (b < ST_SYSTEM) ? b : 8'd0;
					if (b == ST_META) begin
						at = AT_META_TYPE;
						cut = ERR_CUT_META;
					end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
						to_delta();
						at = AT_SYSEX_LEN;
						cut = ERR_BAD_SYSEX;
					end else begin
						at = AT_DATA1;
						cut = ERR_CUT_EVENT;
					end
				end
			end
			AT_DATA1: begin
				held = b[6:0];
				if (one_data(status)) begin
					finish_event(7'd0);
					return;
				end
				at = AT_DATA2;
				cut = ERR_CUT_EVENT;
			end
			AT_DATA2: finish_event(b[6:0]);
			AT_META_TYPE: begin
				meta_kind = b;
				to_delta();
				at = AT_META_LEN;
				cut = ERR_META_LEN;
			end
			AT_META_LEN: begin
				vl = feed_varlen(b);
				if (vl == VL_LONG) begin
					fail_with(ERR_META_LEN);
					return;
				end
				cut = ERR_META_LEN;
				if (vl == VL_DONE) begin
					bytes_left = vl_acc;
					if (bytes_left == 28'd0) begin
						to_delta();
						cut = ERR_NONE;
					end else begin
						tempo_acc = '0;
						at = (meta_kind == META_TEMPO && bytes_left == TEMPO_LEN) ?
							AT_TEMPO_BODY : AT_META_BODY;
					end
				end
			end
			AT_META_BODY, AT_TEMPO_BODY: begin
				was_tempo = at == AT_TEMPO_BODY;
				if (was_tempo)
					tempo_acc = {tempo_acc[15:0], b};
				bytes_left = bytes_left - 28'd1;
				if (bytes_left == 28'd0) begin
					to_delta();
					if (was_tempo && !smpte_mode)
						emit(KIND_TEMPO, 4'd0, 7'd0, 7'd0, 14'd0,
							tempo_acc != 24'd0 ? tempo_acc : TEMPO_DEFAULT, ERR_NONE);
				end else
					cut = ERR_META_LEN;
			end
			AT_SYSEX_LEN: begin
				vl = feed_varlen(b);
				if (vl == VL_LONG) begin
					fail_with(ERR_BAD_SYSEX);
					return;
				end
				cut = ERR_BAD_SYSEX;
				if (vl == VL_DONE) begin
					bytes_left = vl_acc;
					if (bytes_left == 28'd0) begin
						to_delta();
						cut = ERR_NONE;
					end else
						at = AT_SYSEX_BODY;
				end
			end
			AT_SYSEX_BODY: begin
				bytes_left = bytes_left - 28'd1;
				if (bytes_left == 28'd0)
					to_delta();
				else
					cut = ERR_BAD_SYSEX;
			end
			default: begin
				at = AT_DELTA;
				vl = feed_varlen(b);
				if (vl == VL_LONG) begin
					fail_with(ERR_BAD_DELTA);
					return;
				end
				if (vl == VL_MORE)
					cut = ERR_BAD_DELTA;
				else begin
					tick_sum = tick_sum + {4'd0, vl_acc};
					at = AT_STATUS;
					cut = ERR_END_DELTA;
				end
			end
			endcase
			if (last && cut != ERR_NONE)
				fail_with(cut);
		endfunction

		local function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				fail_count++;
			end
		endfunction

		function void check_event(track_event_t got);
			track_event_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual kind %0d tick %0h",
					$time, got.kind, got.tick);
				fail_count++;
				return;
			end
			want = pending.pop_front();
			compare_field("event_kind", 32'(want.kind), 32'(got.kind));
			compare_field("channel", 32'(want.chan), 32'(got.chan));
			compare_field("first_data", 32'(want.data_a), 32'(got.data_a));
			compare_field("second_data", 32'(want.data_b), 32'(got.data_b));
			compare_field("bend_value", 32'(want.bend), 32'(got.bend));
			compare_field("event_tick", want.tick, got.tick);
			compare_field("tempo_us", 32'(want.tempo), 32'(got.tempo));
			compare_field("error_code", 32'(want.err), 32'(got.err));
		endfunction
	endclass

endpackage

FILE: bench/midi_track_event_parser_tb.sv
// Testbench top for midi_track_event_parser: builds track byte streams, drives
// the byte channel, stalls the event channel and checks every event.
// Depends on mtp_pkg, mtp_if, the parser RTL and mtp_event_scoreboard_pkg.
module midi_track_event_parser_tb;
	import mtp_pkg::*;
	import mtp_event_scoreboard_pkg::*;

	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int STALL_LIMIT     = 1000;

	// kinds of generated track
	localparam int MIX_NORMAL = 0;
	localparam int MIX_DENSE  = 1;
	localparam int MIX_WRAP   = 2;

	typedef struct {
		logic [7:0] b;
		bit         first;
		bit         last;
	} track_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	midi_byte_if  track_bus();
	midi_event_if event_bus();

	midi_track_event_parser #(
		.MAX_VARLEN_BYTES(MAX_VARLEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.track(track_bus),
		.events(event_bus)
	);

	track_event_scoreboard sb;
	track_item_t           plan[$];
	bit                    quiet = 1'b0;
	bit                    hold_off_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function void append_item(logic [7:0] b, bit first, bit last);
		track_item_t it;
		it.b = b;
		it.first = first;
		it.last = last;
		plan.insert(plan.size(), it);
	endfunction

	function void push_byte(logic [7:0] b);
		append_item(b, 1'b0, 1'b0);
	endfunction

	// Encode value in exactly nbytes bytes; five bytes never terminate in time.
	function void add_varlen(logic [27:0] value, int nbytes);
		logic [34:0] wide;
		wide = {7'd0, value};
		for (int i = nbytes - 1; i >= 0; i--)
			push_byte({i != 0, wide[7 * i +: 7]});
	endfunction

	function void add_length(int len);
		int nb;
		nb = (len < 128) ? 1 : 2;
		if ($urandom_range(0, 7) == 0)
			nb++;
		add_varlen(28'(len), nb);
	endfunction

	function void add_noise();
		int n;
		n = $urandom_range(4, 12);
		repeat (n)
			append_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
				$urandom_range(0, 7) == 0);
	endfunction

	function void build_track(int mix);
		int         start, n_events, choice, len, cut_at;
		logic [7:0] st;
		logic [7:0] run_st;
		logic [6:0] d2;
		bit         have_running, broken, explicit_st, zero_body;
		start = plan.size();
		broken = mix == MIX_NORMAL && $urandom_range(0, 3) == 0;
		have_running = 1'b0;
		run_st = 8'd0;
		n_events = (mix == MIX_NORMAL) ? $urandom_range(1, 8) : 16;
		repeat (n_events) begin
			if (mix == MIX_WRAP)
				add_varlen(28'(28'hFFFFFFF - $urandom_range(0, 255)), 4);
			else begin
				choice = $urandom_range(0, broken ? 10 : 9);
				case (choice)
				0: add_varlen(28'd0, 1);
				6, 7: add_varlen(28'($urandom_range(0, 16383)), 2);
				8: add_varlen(28'($urandom_range(0, 2097151)), 3);
				9: add_varlen(28'($urandom()), 4);
				10: add_varlen(28'($urandom()), 5);
				default: add_varlen(28'($urandom_range(1, 127)), 1);
				endcase
			end
			choice = (mix == MIX_NORMAL) ? $urandom_range(0, broken ? 11 : 8) : 0;
			case (choice)
			4: begin
				push_byte(ST_META);
				if ($urandom_range(0, 1)) begin
					push_byte(META_TEMPO);
					len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 3;
				end else begin
					push_byte(8'($urandom_range(0, 255)));
					len = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 200) :
						$urandom_range(0, 6);
				end
				add_length(len);
				zero_body = $urandom_range(0, 5) == 0;
				repeat (len)
					push_byte(zero_body ? 8'h00 : 8'($urandom_range(0, 255)));
				have_running = 1'b0;
			end
			5: begin
				push_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
				len = $urandom_range(0, 6);
				add_length(len);
				repeat (len)
					push_byte(8'($urandom_range(0, 255)));
				have_running = 1'b0;
			end
			6: begin
				do
					st = 8'($urandom_range(8'hF1, 8'hFE));
				while (st == ST_SYSEX_ESC);
				push_byte(st);
				push_byte(8'($urandom_range(0, 255)));
				push_byte(8'($urandom_range(0, 255)));
				have_running = 1'b0;
			end
			9: begin
				push_byte(ST_META);
				push_byte(8'($urandom_range(0, 255)));
				add_varlen(28'($urandom()), 5);
			end
			10: begin
				push_byte(ST_SYSEX);
				add_varlen(28'($urandom()), 5);
			end
			11: begin
				// garbage: may be a data byte with no running status
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(0, 255)));
				have_running = 1'b0;
			end
			default: begin
				explicit_st = !have_running || $urandom_range(0, 1);
				if (explicit_st) begin
					st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
					if (mix == MIX_DENSE)
						st[7:4] = HI_NOTE_ON;
					else if (mix == MIX_WRAP)
						st[7:4] = HI_PROGRAM;
					push_byte(st);
					run_st = st;
					have_running = 1'b1;
				end
				// data bytes with bit 7 set only where a status cannot be taken
				push_byte({explicit_st && $urandom_range(0, 15) == 0,
					7'($urandom_range(0, 127))});
				if (run_st[7:4] != HI_PROGRAM && run_st[7:4] != HI_PRESSURE) begin
					d2 = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
					push_byte({$urandom_range(0, 15) == 0, d2});
				end
			end
			endcase
		end
		// end-of-track meta
		push_byte(ST_META);
		push_byte(8'h2F);
		push_byte(8'h00);
		plan[start].first = mix != MIX_NORMAL || $urandom_range(0, 4) != 0;
		if (broken && $urandom_range(0, 1)) begin
			cut_at = $urandom_range(start, plan.size() - 1);
			while (plan.size() > cut_at + 1)
				void'(plan.pop_back());
		end
		plan[plan.size() - 1].last = 1'b1;
	endfunction

	task automatic drive_plan(bit gappy);
		track_item_t it;
		while (plan.size() != 0) begin
			it = plan.pop_front();
			if (gappy && !quiet && $urandom_range(0, 5) == 0) begin
				track_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			track_bus.valid <= 1'b1;
			track_bus.track_byte <= it.b;
			track_bus.first_in_track <= it.first;
			track_bus.last_in_track <= it.last;
			do @(posedge clk); while (!track_bus.ready);
			sb.note_byte(it.b, it.first, it.last);
		end
	endtask

	// Hold the byte channel until every expected event has come out.
	task automatic wait_drained();
		track_bus.valid <= 1'b0;
		do @(posedge clk); while (!sb.idle());
	endtask

	task automatic write_mode(bit m);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_mode(m);
	endtask

	task automatic run_random(int budget);
		int sent;
		int pick;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 39);
			if (pick < 4)
				add_noise();
			else if (pick == 4)
				build_track(MIX_WRAP);
			else
				build_track(MIX_NORMAL);
			sent += plan.size();
			drive_plan($urandom_range(0, 3) != 0);
		end
	endtask

	task automatic load_directed();
		int start;
		start = plan.size();
		push_byte(8'h00); push_byte(8'h90); push_byte(8'h3C); push_byte(8'h7F);
		// running status note on with velocity zero
		push_byte(8'h00); push_byte(8'h3C); push_byte(8'h00);
		// longest delta, then bend at both extremes
		push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h7F);
		push_byte(8'hE5); push_byte(8'h00); push_byte(8'h00);
		push_byte(8'h00); push_byte(8'h7F); push_byte(8'hFF);
		// tempo of zero falls back to the default
		push_byte(8'h00); push_byte(ST_META); push_byte(META_TEMPO); push_byte(8'h03);
		push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
		plan[start].first = 1'b1;
		plan[plan.size() - 1].last = 1'b1;
		start = plan.size();
		push_byte(8'h00); push_byte(8'hC7); push_byte(8'h85);
		push_byte(8'h00); push_byte(8'hBF); push_byte(8'h07); push_byte(8'h64);
		push_byte(8'h00); push_byte(ST_SYSEX); push_byte(8'h01); push_byte(ST_SYSEX_ESC);
		plan[start].first = 1'b1;
		plan[plan.size() - 1].last = 1'b1;
	endtask

	initial begin : stimulus
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		track_bus.valid <= 1'b0;
		track_bus.track_byte <= 8'd0;
		track_bus.first_in_track <= 1'b0;
		track_bus.last_in_track <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);
		load_directed();
		drive_plan(1'b0);

		write_mode(1'b1);
		run_random(300);

		write_mode(1'b0);
		run_random(150);
		wait_drained();
		run_random(150);

		write_mode(1'b1);
		hold_off_req = 1'b1;
		build_track(MIX_DENSE);
		drive_plan(1'b0);
		run_random(300);

		write_mode(1'b0);
		run_random(200);
		quiet = 1'b1;
		run_random(150);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : event_sink
		int stall;
		bit idles;
		stall = 0;
		idles = 1'b1;
		event_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0)
				idles = !idles;
			if (hold_off_req) begin
				// long hold-off so the result queue fills and the input stalls
				event_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!quiet && stall > 0) begin
				event_bus.ready <= 1'b0;
				stall--;
			end else if (!quiet && idles && $urandom_range(0, 5) == 0) begin
				event_bus.ready <= 1'b0;
				stall = $urandom_range(0, 3);
			end else
				event_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : event_monitor
		track_event_t seen;
		if (event_bus.valid && event_bus.ready) begin
			seen.kind = event_bus.event_kind;
			seen.chan = event_bus.channel;
			seen.data_a = event_bus.first_data;
			seen.data_b = event_bus.second_data;
			seen.bend = event_bus.bend_value;
			seen.tick = event_bus.event_tick;
			seen.tempo = event_bus.tempo_us;
			seen.err = event_bus.error_code;
			sb.check_event(seen);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((track_bus.valid && track_bus.ready) || (event_bus.valid && event_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
